// File: hdl/scrolling_seven_segment_driver_macros.svh
// assertion helpers used by the checker file
`ifndef SCROLLING_SEVEN_SEGMENT_DRIVER_MACROS_SVH
`define SCROLLING_SEVEN_SEGMENT_DRIVER_MACROS_SVH

// same-cycle implication, quiet while reset is held
`define SSSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while reset is held
`define SSSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also runs through reset
`define SSSD_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/sssd_pkg.sv
`default_nettype none

package sssd_pkg;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_RESTART = 2'd1,
    OP_SCROLL  = 2'd2,
    OP_REFRESH = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [5:0] position;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [1:0] digit_index;
    logic [7:0] segments;
    logic [5:0] window_start;
  } out_item_t;

  localparam int LEN_W = 7;

  localparam logic [7:0] SEG_BLANK = 8'h00;
  localparam logic [7:0] SEG_DASH  = 8'h40;
  localparam logic [7:0] SEG_DP    = 8'h80;
  localparam logic [7:0] SEG_UNDER = 8'h08;

  // ascii to gfedcba, dp in bit 7; letters of either case share a pattern
  function automatic logic [7:0] seg_decode(input logic [7:0] c);
    logic [7:0] u;
    logic [7:0] s;
    u = (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
    case (u)
      8'h2D: s = SEG_DASH;
      8'h2E: s = SEG_DP;
      8'h5F: s = SEG_UNDER;
      8'h30: s = 8'h3F;
      8'h31: s = 8'h06;
      8'h32: s = 8'h5B;
      8'h33: s = 8'h4F;
      8'h34: s = 8'h66;
      8'h35: s = 8'h6D;
      8'h36: s = 8'h7D;
      8'h37: s = 8'h07;
      8'h38: s = 8'h7F;
      8'h39: s = 8'h6F;
      8'h41: s = 8'h77;
      8'h42: s = 8'h7C;
      8'h43: s = 8'h39;
      8'h44: s = 8'h5E;
      8'h45: s = 8'h79;
      8'h46: s = 8'h71;
      8'h47: s = 8'h3D;
      8'h48: s = 8'h76;
      8'h49: s = 8'h30;
      8'h4A: s = 8'h1E;
      8'h4B: s = 8'h75;
      8'h4C: s = 8'h38;
      8'h4D: s = 8'h55;
      8'h4E: s = 8'h54;
      8'h4F: s = 8'h5C;
      8'h50: s = 8'h73;
      8'h51: s = 8'h67;
      8'h52: s = 8'h50;
      8'h53: s = 8'h6D;
      8'h54: s = 8'h78;
      8'h55: s = 8'h3E;
      8'h56: s = 8'h1C;
      8'h57: s = 8'h1D;
      8'h58: s = 8'h64;
      8'h59: s = 8'h6E;
      8'h5A: s = 8'h5B;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// File: hdl/scrolling_seven_segment_driver.sv
// channel   direction  payload                    handshake
// in_       input      sssd_pkg::in_item_t        in_valid / in_stall
// out_      output     sssd_pkg::out_item_t       out_valid / out_stall
// cfg_      input      scroll length, 7 bits      cfg_we, no wait
//
// one transfer per cycle on the input while in_stall is low; each result passes through
// the registered read of the string store and the output register
// rst_n is synchronous: scroll state, digit counter and window clear, the store does not
// in_stall rises only while both the read stage and the output register are held
`default_nettype none

module scrolling_seven_segment_driver #(
  parameter int DIGITS       = 4,
  parameter int STRING_DEPTH = 64
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  sssd_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  wire                  out_stall,
  output sssd_pkg::out_item_t  out_item,
  input  wire                  cfg_we,
  input  wire [sssd_pkg::LEN_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(STRING_DEPTH);
  localparam int DW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int CL = $clog2(STRING_DEPTH + 1);
  localparam int LW = (CL > sssd_pkg::LEN_W) ? CL + 1 : sssd_pkg::LEN_W + 1;
  localparam int RW = 11;

  // control and scroll state
  logic [sssd_pkg::LEN_W-1:0] len_r;
  logic [AW-1:0]              pos_r, pos_nxt;
  logic                       up_r, up_nxt;
  logic [DW-1:0]              dig_r, dig_nxt;
  logic [7:0]                 win_r [DIGITS];

  // read stage
  logic          s1_v_r;
  logic          s1_scroll_r;
  logic [DW-1:0] s1_dig_r;
  logic [AW-1:0] s1_pos_r;

  // output register
  logic                 out_valid_r;
  sssd_pkg::out_item_t  out_item_r, out_item_nxt;

  logic          accept, out_free, s1_go;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr [DIGITS];
  logic [7:0]    rd_data [DIGITS];

  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_v_r && out_free;
  assign in_stall = s1_v_r && !out_free;
  assign accept   = in_valid && !in_stall;
  assign wr_en    = accept && (in_item.op == sssd_pkg::OP_WRITE);
  assign rd_en    = accept && (in_item.op == sssd_pkg::OP_SCROLL);

  // write address wraps on the store depth
  always_comb begin
    logic [RW-1:0] wa;
    wa = RW'(in_item.position);
    for (int k = 2; k >= 0; k--) begin
      if (wa >= (RW'(STRING_DEPTH) << k)) begin
        wa = wa - (RW'(STRING_DEPTH) << k);
      end
    end
    wr_addr = wa[AW-1:0];
  end

  // one store copy per digit so the whole window is read in parallel
  for (genvar g = 0; g < DIGITS; g++) begin : g_lane
    logic [7:0]  bank [STRING_DEPTH];
    logic [7:0]  rd_q;
    logic [AW:0] sum;

    always_comb begin
      sum = {1'b0, pos_r} + (AW + 1)'(g);
      if (sum >= (AW + 1)'(STRING_DEPTH)) begin
        sum = sum - (AW + 1)'(STRING_DEPTH);
      end
    end
    assign rd_addr[g] = sum[AW-1:0];

    always_ff @(posedge clk) begin
      if (wr_en) begin
        bank[wr_addr] <= in_item.char_code;
      end
      if (rd_en) begin
        rd_q <= bank[rd_addr[g]];
      end
    end
    assign rd_data[g] = rd_q;
  end

  // scroll position and digit counter update at the transfer
  always_comb begin
    logic signed [LW-1:0] lenc, limit, p_s;
    pos_nxt = pos_r;
    up_nxt  = up_r;
    dig_nxt = dig_r;
    lenc    = (LW'(len_r) > LW'(STRING_DEPTH)) ? LW'(STRING_DEPTH) : LW'(len_r);
    limit   = lenc - LW'(DIGITS);
    p_s     = LW'(pos_r);
    if (accept) begin
      case (in_item.op)
        sssd_pkg::OP_RESTART: begin
          pos_nxt = '0;
          up_nxt  = 1'b1;
        end
        sssd_pkg::OP_SCROLL: begin
          if (up_r) begin
            if (p_s < limit) begin
              pos_nxt = pos_r + AW'(1);
              if (p_s + LW'(1) == limit) begin
                up_nxt = 1'b0;
              end
            end
          end else if (pos_r != '0) begin
            pos_nxt = pos_r - AW'(1);
            if (pos_r == AW'(1)) begin
              up_nxt = 1'b1;
            end
          end
        end
        sssd_pkg::OP_REFRESH: begin
          dig_nxt = (dig_r == DW'(DIGITS - 1)) ? '0 : dig_r + DW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // result of the item in the read stage; a fresh window bypasses win_r
  always_comb begin
    logic [7:0]      ch;
    logic [AW+5:0]   pos_ext;
    logic [DW+1:0]   dig_ext;
    ch      = s1_scroll_r ? rd_data[s1_dig_r] : win_r[s1_dig_r];
    pos_ext = (AW + 6)'(s1_pos_r);
    dig_ext = (DW + 2)'(s1_dig_r);
    out_item_nxt.digit_index  = dig_ext[1:0];
    out_item_nxt.segments     = sssd_pkg::seg_decode(ch);
    out_item_nxt.window_start = pos_ext[5:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      pos_r       <= '0;
      up_r        <= 1'b1;
      dig_r       <= '0;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < DIGITS; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        len_r <= cfg_wdata;
      end
      pos_r <= pos_nxt;
      up_r  <= up_nxt;
      dig_r <= dig_nxt;
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
      if (out_free) begin
        out_valid_r <= s1_v_r;
      end
      if (s1_go && s1_scroll_r) begin
        for (int i = 0; i < DIGITS; i++) begin
          win_r[i] <= rd_data[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_scroll_r <= (in_item.op == sssd_pkg::OP_SCROLL);
      s1_dig_r    <= dig_nxt;
      s1_pos_r    <= pos_nxt;
    end
    if (s1_go) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// File: hdl/sssd_checker.sv
`default_nettype none
`include "scrolling_seven_segment_driver_macros.svh"

module sssd_checker #(
  parameter int DIGITS       = 4
) (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_stall,
  input wire                  out_valid,
  input wire                  out_stall,
  input sssd_pkg::out_item_t  out_item
);

  // a held result keeps its payload
  `SSSD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "result changed while stalled")

  // the input only backs up behind a held result
  `SSSD_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled with free output")

  // nothing leaves straight out of reset
  `SSSD_ASSERT_RST(a_reset_empty, !rst_n, !out_valid, "result present after reset")

  // digit in range of the display
  `SSSD_ASSERT_NOW(a_digit_range, out_valid && (DIGITS < 4), out_item.digit_index < 2'(DIGITS), "digit index beyond display")

endmodule

bind scrolling_seven_segment_driver sssd_checker #(
  .DIGITS(DIGITS)
) u_sssd_checker (.*);

`default_nettype wire

// File: verif/scrolling_seven_segment_driver_test.sv
module scrolling_seven_segment_driver_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int STORE_DEPTH = 64;
  localparam int WINDOW_DIGITS = 4;

  localparam logic [0:9][7:0] DIGIT_GLYPH = {
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };
  localparam logic [0:25][7:0] LETTER_GLYPH = {
    8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D, 8'h76, 8'h30, 8'h1E,
    8'h75, 8'h38, 8'h55, 8'h54, 8'h5C, 8'h73, 8'h67, 8'h50, 8'h6D, 8'h78,
    8'h3E, 8'h1C, 8'h1D, 8'h64, 8'h6E, 8'h5B
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  sssd_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sssd_pkg::out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [sssd_pkg::LEN_W-1:0] cfg_wdata = '0;

  scrolling_seven_segment_driver u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  sssd_pkg::in_item_t pending_items[$];
  sssd_pkg::out_item_t expected_display[$];

  // shadow of the display state
  logic [7:0] text_store [0:STORE_DEPTH-1];
  logic [7:0] window_q [0:WINDOW_DIGITS-1];
  logic [5:0] scroll_pos = '0;
  bit moving_up = 1'b1;
  logic [1:0] digit_sel = '0;
  logic [sssd_pkg::LEN_W-1:0] scroll_len = '0;

  // which store entries the stimulus has filled so far
  bit loaded [0:STORE_DEPTH-1];
  int loaded_count = 0;

  bit idle_on = 1'b1;
  int send_gap = 0;
  int stall_left = 0;
  int cycle_count = 0;
  int items_sent = 0;
  int display_checked = 0;
  int scroll_steps = 0;
  int turns = 0;
  int settings_used = 1;
  int fault_count = 0;

  function automatic logic [7:0] glyph_segments(input logic [7:0] ch);
    logic [7:0] pat;
    pat = 8'h00;
    if (ch == "-") begin
      pat = 8'h40;
    end else if (ch == ".") begin
      pat = 8'h80;
    end else if (ch == "_") begin
      pat = 8'h08;
    end else if (ch >= "0" && ch <= "9") begin
      pat = DIGIT_GLYPH[ch - "0"];
    end else if (ch >= "A" && ch <= "Z") begin
      pat = LETTER_GLYPH[ch - "A"];
    end else if (ch >= "a" && ch <= "z") begin
      pat = LETTER_GLYPH[ch - "a"];
    end
    return pat;
  endfunction

  task automatic predict_display(input sssd_pkg::in_item_t it);
    int len;
    int lim;
    int p;
    sssd_pkg::out_item_t res;
    case (it.op)
      sssd_pkg::OP_WRITE: begin
        text_store[it.position] = it.char_code;
      end
      sssd_pkg::OP_RESTART: begin
        scroll_pos = '0;
        moving_up = 1'b1;
      end
      sssd_pkg::OP_SCROLL: begin
        for (int i = 0; i < WINDOW_DIGITS; i++)
          window_q[i] = text_store[6'(scroll_pos + i)];
        len = (scroll_len > STORE_DEPTH) ? STORE_DEPTH : int'(scroll_len);
        lim = len - WINDOW_DIGITS;
        p = scroll_pos;
        // turning down at the top ends the step; no fall in the same step
        if (moving_up && p < lim) begin
          p++;
          if (p == lim) begin
            moving_up = 1'b0;
            turns++;
          end
        end else if (!moving_up && p > 0) begin
          p--;
          if (p == 0) begin
            moving_up = 1'b1;
            turns++;
          end
        end
        scroll_pos = p[5:0];
        scroll_steps++;
      end
      default: begin
        digit_sel = digit_sel + 2'd1;
      end
    endcase
    res.digit_index = digit_sel;
    res.segments = glyph_segments(window_q[digit_sel]);
    res.window_start = scroll_pos;
    expected_display.push_back(res);
  endtask

  function automatic logic [7:0] random_glyph();
    logic [7:0] ch;
    if ($urandom_range(0, 7) == 0)
      ch = 8'($urandom_range(0, 255));
    else
      ch = 8'($urandom_range(8'h20, 8'h7E));
    return ch;
  endfunction

  task automatic queue_item(input sssd_pkg::op_t op, input logic [5:0] pos,
                            input logic [7:0] ch);
    sssd_pkg::in_item_t it;
    it.op = op;
    it.position = pos;
    it.char_code = ch;
    if (op == sssd_pkg::OP_WRITE && !loaded[pos]) begin
      loaded[pos] = 1'b1;
      loaded_count++;
    end
    pending_items.push_back(it);
  endtask

  task automatic queue_random(input int n);
    int k;
    int pick;
    int run;
    int base;
    k = 0;
    while (k < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // a fragment of a message in consecutive entries
        run = $urandom_range(4, 8);
        base = $urandom_range(0, STORE_DEPTH - 1);
        for (int j = 0; j < run; j++)
          queue_item(sssd_pkg::OP_WRITE, 6'(base + j), random_glyph());
        k += run;
      end else begin
        if (pick < 20)
          queue_item(sssd_pkg::OP_WRITE, 6'($urandom_range(0, 63)),
                     8'($urandom_range(0, 255)));
        else if (pick < 23)
          queue_item(sssd_pkg::OP_RESTART, 6'($urandom_range(0, 63)),
                     8'($urandom_range(0, 255)));
        else if (pick < 48 || loaded_count != STORE_DEPTH)
          queue_item(sssd_pkg::OP_REFRESH, 6'($urandom_range(0, 63)),
                     8'($urandom_range(0, 255)));
        else
          queue_item(sssd_pkg::OP_SCROLL, 6'($urandom_range(0, 63)),
                     8'($urandom_range(0, 255)));
        k++;
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_display.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_scroll_length(input logic [sssd_pkg::LEN_W-1:0] len);
    wait_drained();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    scroll_len = len;
    settings_used++;
  endtask

  task automatic run_setting(input logic [sssd_pkg::LEN_W-1:0] len, input int n,
                             input bit idle);
    set_scroll_length(len);
    idle_on = idle;
    queue_random(n);
  endtask

  // input side
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_display(in_item);
        items_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_items.size() != 0) begin
          in_valid <= 1'b1;
          in_item <= pending_items.pop_front();
          if (idle_on && $urandom_range(0, 9) == 0)
            send_gap <= $urandom_range(1, 10);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    sssd_pkg::out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_display.size() == 0) begin
          if (fault_count < 10)
            $display("display result with nothing pending: %p", out_item);
          fault_count++;
        end else begin
          want = expected_display.pop_front();
          display_checked++;
          if (out_item.digit_index !== want.digit_index ||
              out_item.segments !== want.segments ||
              out_item.window_start !== want.window_start) begin
            if (fault_count < 10)
              $display("display mismatch at cycle %0d: digit %0d/%0d seg %h/%h start %0d/%0d",
                       cycle_count, want.digit_index, out_item.digit_index,
                       want.segments, out_item.segments,
                       want.window_start, out_item.window_start);
            fault_count++;
          end
        end
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(0, 9);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timed out with %0d results outstanding", expected_display.size());
      $display("scrolling_seven_segment_driver_test: errors");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      loaded[i] = 1'b0;
      text_store[i] = 8'h00;
    end
    for (int i = 0; i < WINDOW_DIGITS; i++)
      window_q[i] = 8'h00;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset length of zero keeps the window at entry 0
    queue_item(sssd_pkg::OP_REFRESH, 6'd0, 8'h00);
    queue_item(sssd_pkg::OP_WRITE, 6'd0, "-");
    queue_item(sssd_pkg::OP_WRITE, 6'd1, ".");
    queue_item(sssd_pkg::OP_WRITE, 6'd2, "_");
    queue_item(sssd_pkg::OP_WRITE, 6'd3, 8'h00);
    queue_item(sssd_pkg::OP_SCROLL, 6'd63, 8'hFF);
    for (int i = 0; i < 4; i++)
      queue_item(sssd_pkg::OP_REFRESH, 6'd0, 8'h00);
    queue_item(sssd_pkg::OP_WRITE, 6'd0, 8'hFF);
    queue_item(sssd_pkg::OP_WRITE, 6'd1, "/");
    queue_item(sssd_pkg::OP_WRITE, 6'd2, "{");
    queue_item(sssd_pkg::OP_WRITE, 6'd3, "a");
    queue_item(sssd_pkg::OP_WRITE, 6'd63, "9");
    queue_item(sssd_pkg::OP_SCROLL, 6'd0, 8'h00);
    for (int i = 0; i < 4; i++)
      queue_item(sssd_pkg::OP_REFRESH, 6'd63, 8'hFF);
    queue_item(sssd_pkg::OP_RESTART, 6'd63, 8'hFF);
    queue_item(sssd_pkg::OP_SCROLL, 6'd0, 8'h00);

    // fill the whole store before the window can move past entry 3
    set_scroll_length(7'd4);
    for (int i = 0; i < STORE_DEPTH; i++)
      queue_item(sssd_pkg::OP_WRITE, 6'(i), random_glyph());
    queue_random(70);

    run_setting(7'd64, 110, 1'b1);
    run_setting(7'd127, 90, 1'b1);
    run_setting(7'd5, 70, 1'b1);
    run_setting(7'd0, 40, 1'b1);
    run_setting(7'($urandom_range(6, 63)), 100, 1'b1);
    run_setting(7'd100, 80, 1'b1);
    run_setting(7'd1, 30, 1'b1);
    run_setting(7'($urandom_range(0, 127)), 100, 1'b0);

    wait_drained();
    repeat (10) @(posedge clk);
    fault_count += expected_display.size();

    $display("%0d transfers in, %0d display results checked under %0d scroll lengths",
             items_sent, display_checked, settings_used);
    $display("%0d scroll steps taken, %0d direction reversals", scroll_steps, turns);
    if (fault_count == 0) begin
      $display("scrolling_seven_segment_driver_test: clean");
    end else begin
      $display("%0d failures", fault_count);
      $display("scrolling_seven_segment_driver_test: errors");
    end
    $finish;
  end

endmodule
